[src/sitda_pkg.sv]
// shared types and constants for the signed integer to decimal text unit
package sitda_pkg;

	// sign and magnitude of one classified item
	typedef struct packed {
		logic        neg;
		logic [31:0] mag;
	} item_t;

	localparam logic [7:0]  DIGIT_ZERO  = 8'd48;
	localparam logic [7:0]  MINUS_SIGN  = 8'd45;
	localparam logic [3:0]  RADIX       = 4'd10;
	localparam int          MAX_DIGITS  = 10;
	localparam int          DIGIT_IDX_W = 4;
	// ceil(2^35 / 10): x / 10 == (x * RECIP_TEN) >> 35 for every 32-bit x
	localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

endpackage

[src/sitda_front.sv]
// front end: accepts a value and splits it into sign and magnitude
module sitda_front (
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  value,
	output logic                push,
	output sitda_pkg::item_t    push_item,
	input  logic                q_full
);

	logic [31:0] raw;

	// accept whenever the queue has a free slot
	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	// magnitude in 32 unsigned bits, the most negative value wraps onto itself
	assign raw            = value;
	assign push_item.neg  = raw[31];
	assign push_item.mag  = raw[31] ? (~raw + 32'd1) : raw;

endmodule

[src/sitda_queue.sv]
// two-entry queue between the front end and the converter
module sitda_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sitda_pkg::item_t push_item,
	output logic             full,
	input  logic             pop,
	output logic             pop_valid,
	output sitda_pkg::item_t pop_item
);

	sitda_pkg::item_t mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_item  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

[src/sitda_back.sv]
// back end: digit extraction by reciprocal multiply and character output
module sitda_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  sitda_pkg::item_t q_item,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       char_code,
	output logic             last_char
);

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_CONV = 3'b010,
		B_EMIT = 3'b100
	} back_state_t;

	localparam logic [sitda_pkg::DIGIT_IDX_W-1:0] IDX_ONE =
		{{(sitda_pkg::DIGIT_IDX_W-1){1'b0}}, 1'b1};

	back_state_t                           state_q;
	logic                                  neg_q;
	logic [31:0]                           cur_q;
	logic [3:0]                            prev_q;
	logic                                  pend_q;
	logic                                  done_q;
	logic [sitda_pkg::DIGIT_IDX_W-1:0]     cnt_q;
	logic [sitda_pkg::DIGIT_IDX_W-1:0]     rd_q;
	logic                                  sign_pend_q;
	logic [3:0]                            digits_q [sitda_pkg::MAX_DIGITS];
	logic                                  out_valid_q;
	logic [7:0]                            char_q;
	logic                                  last_q;

	logic [63:0] prod;
	logic [31:0] quot;
	logic [7:0]  times_ten;
	logic [3:0]  digit;
	logic        slot_free;

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last_char = last_q;

	assign pop       = (state_q == B_IDLE) && q_valid;
	assign slot_free = !out_valid_q || out_ready;

	// divide by ten
	assign prod = {32'd0, cur_q} * {32'd0, sitda_pkg::RECIP_TEN};
	assign quot = 32'(prod >> sitda_pkg::RECIP_SHIFT);

	// remainder of the previous division: only the low four bits matter
	assign times_ten = {4'd0, cur_q[3:0]} * {4'd0, sitda_pkg::RADIX};
	assign digit     = prev_q - times_ten[3:0];

	// digit store, written least significant first
	always_ff @(posedge clk) begin
		if (state_q == B_CONV && pend_q) begin
			digits_q[cnt_q] <= digit;
		end
	end

	// output character register
	always_ff @(posedge clk) begin
		if (state_q == B_EMIT && slot_free) begin
			if (sign_pend_q) begin
				char_q <= sitda_pkg::MINUS_SIGN;
				last_q <= 1'b0;
			end else begin
				char_q <= sitda_pkg::DIGIT_ZERO + {4'd0, digits_q[rd_q]};
				last_q <= (rd_q == '0);
			end
		end
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			neg_q       <= 1'b0;
			cur_q       <= '0;
			prev_q      <= '0;
			pend_q      <= 1'b0;
			done_q      <= 1'b0;
			cnt_q       <= '0;
			rd_q        <= '0;
			sign_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// output valid: set when a character is loaded, cleared once taken
			if (state_q == B_EMIT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						neg_q   <= q_item.neg;
						cur_q   <= q_item.mag;
						pend_q  <= 1'b0;
						done_q  <= 1'b0;
						cnt_q   <= '0;
						state_q <= B_CONV;
					end
				end
				B_CONV: begin
					if (!done_q) begin
						cur_q  <= quot;
						prev_q <= cur_q[3:0];
						pend_q <= 1'b1;
						if (quot == '0) begin
							done_q <= 1'b1;
						end
					end
					if (pend_q) begin
						cnt_q <= cnt_q + IDX_ONE;
						if (done_q) begin
							rd_q        <= cnt_q;
							sign_pend_q <= neg_q;
							pend_q      <= 1'b0;
							state_q     <= B_EMIT;
						end
					end
				end
				B_EMIT: begin
					if (slot_free) begin
						if (sign_pend_q) begin
							sign_pend_q <= 1'b0;
						end else if (rd_q == '0) begin
							state_q <= B_IDLE;
						end else begin
							rd_q <= rd_q - IDX_ONE;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

[src/signed_int_to_decimal_ascii_unit.sv]
// top level of the signed integer to decimal text unit
// Converts each 32-bit two's-complement value into its decimal ASCII text, one character per
// output item, most significant first, with a leading '-' for negative values and last_char
// set on the final character; the most negative value gives "-2147483648". The converter
// loads a value, runs one division by ten per digit in the reciprocal multiplier and then
// drains, after which the characters (one more than the digits when negative) leave
// through the output register. A two-entry queue in front of the converter lets new
// values be taken while an earlier one is still being converted or sent out.
module signed_int_to_decimal_ascii_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         char_code,
	output logic               last_char
);

	logic             push;
	sitda_pkg::item_t push_item;
	logic             q_full;
	logic             pop;
	logic             q_valid;
	sitda_pkg::item_t q_item;

	// accept and classify
	sitda_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	// decoupling queue
	sitda_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_valid (q_valid),
		.pop_item  (q_item)
	);

	// convert and send characters
	sitda_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_code (char_code),
		.last_char (last_char)
	);

endmodule
